[rtl/pow_difficulty_retarget_defines.svh]
// Assertion macros for the difficulty retarget block.
// Used by the port checker; depends on nothing.
`ifndef POW_DIFFICULTY_RETARGET_DEFINES_SVH
`define POW_DIFFICULTY_RETARGET_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define PDR_ASSERT_IMP(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (a) |-> (b)) \
    else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define PDR_ASSERT_NEXT(lbl, clk, rst, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst) (a) |=> (b)) \
    else $error("assertion failed");
`endif

[rtl/pdr_pkg.sv]
// Package for the difficulty retarget block: constants, request type, compact decode helper.
// No dependencies.
package pdr_pkg;
  localparam int unsigned HeightMain = 1000000;
  localparam int unsigned HeightBandA = 10000;
  localparam int unsigned HeightBandB = 5000;
  localparam logic [1:0] RegTimespan = 2'd0;
  localparam logic [1:0] RegSpacing = 2'd1;
  localparam logic [1:0] RegMode = 2'd2;
  localparam logic [1:0] RegLimit = 2'd3;

  typedef struct packed {
    logic         force_limit;
    logic [255:0] target;
    logic [63:0]  mult;
    logic [63:0]  divisor;
  } pdr_req_t;

  function automatic logic [255:0] compact_decode(input logic [31:0] bits);
    logic [7:0]   size;
    logic [255:0] r;
    begin
      size = bits[31:24];
      r = {233'd0, bits[22:0]};
      if (size <= 8'd3) r = r >> (8 * (3 - size));
      else if (size >= 8'd35) r = '0;
      else r = r << (8 * (size - 8'd3));
      return r;
    end
  endfunction
endpackage

[rtl/pdr_front.sv]
// Front: computes the damped timespan and decodes the target for one request.
// Depends on pdr_pkg.
module pdr_front
  import pdr_pkg::*;
#(
  parameter int unsigned LOOKBACK_WINDOW = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [30:0] last_height_i,
  input  logic [31:0] last_time_i,
  input  logic [31:0] first_time_i,
  input  logic [31:0] last_bits_i,
  input  logic [35:0] window_time_sum_i,
  input  logic [31:0] timespan_i,
  input  logic [31:0] spacing_i,
  input  logic        mode_i,
  output logic        req_valid_o,
  input  logic        req_ready_i,
  output pdr_req_t    req_o
);
  logic     valid_q;
  pdr_req_t req_q, req_d;
  logic [31:0] height;
  logic signed [65:0] t_s, act, r_s, m, lo, hi;
  logic [41:0] wsum_thr;

  assign full_o = valid_q && !req_ready_i;
  assign req_valid_o = valid_q;
  assign req_o = req_q;

  always_comb begin
    height = {1'b0, last_height_i} + 32'd1;
    t_s = $signed({34'd0, timespan_i});
    act = $signed({34'd0, last_time_i}) - $signed({34'd0, first_time_i});
    // floor(sum / window) > limit  <=>  sum >= window * (limit + 1)
    wsum_thr = (42'(last_time_i) + {8'd0, spacing_i, 2'b00} + 42'd1) *
               42'(LOOKBACK_WINDOW);
    r_s = t_s;
    req_d.force_limit = 1'b0;
    if (height < HeightMain) begin
      if (mode_i) begin
        m = t_s + (act - t_s) / 8;
        lo = t_s - t_s / 4;
        hi = t_s + t_s / 2;
      end else begin
        m = act;
        if (height > HeightBandA) lo = t_s / 4;
        else if (height > HeightBandB) lo = t_s / 8;
        else lo = t_s / 16;
        hi = t_s * 4;
      end
    end else begin
      r_s = t_s / 2;
      m = r_s + (act - r_s) / 4;
      lo = r_s / 2;
      hi = r_s * 2;
      req_d.force_limit = {6'd0, window_time_sum_i} >= wsum_thr;
    end
    if (m < lo) m = lo;
    else if (m > hi) m = hi;
    req_d.mult = m[63:0];
    req_d.divisor = r_s[63:0];
    req_d.target = compact_decode(last_bits_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!full_o) begin
      valid_q <= push_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && !full_o) req_q <= req_d;
  end
endmodule

[rtl/pdr_back.sv]
// Back: multiplies by the timespan, divides bit-serially, caps and re-encodes.
// Depends on pdr_pkg.
module pdr_back
  import pdr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  output logic        req_ready_o,
  input  pdr_req_t    req_i,
  input  logic [31:0] limit_bits_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [31:0] next_bits_o,
  output logic        min_difficulty_used_o
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001, S_MUL = 5'b00010, S_DIV = 5'b00100,
    S_ENC = 5'b01000, S_OUT = 5'b10000
  } state_e;
  state_e state_q;
  logic [255:0] acc_q, quo_q, limit;
  logic [63:0]  mult_q, div_q, rem_q;
  logic         force_q, mhalf_q;
  logic [8:0]   cnt_q;
  logic [31:0]  bits_q;
  logic [64:0]  rem_sh;
  logic [31:0]  carry_q, mul_a, mul_b;
  logic [3:0]   mul_widx;
  logic [63:0]  mul_p;
  logic [255:0] capped;
  logic [7:0]   size;
  logic [255:0] sh;
  logic [23:0]  c;

  assign limit = compact_decode(limit_bits_i);
  assign req_ready_o = (state_q == S_IDLE);
  assign empty_o = (state_q != S_OUT);
  assign next_bits_o = bits_q;
  assign min_difficulty_used_o = force_q;
  assign rem_sh = {rem_q, acc_q[255]};

  always_comb begin
    mul_a = acc_q[{cnt_q[2:0], 5'd0} +: 32];
    mul_b = mhalf_q ? mult_q[63:32] : mult_q[31:0];
    mul_widx = {1'b0, cnt_q[2:0]} + {3'd0, mhalf_q};
    mul_p = {32'd0, mul_a} * {32'd0, mul_b} +
            {32'd0, quo_q[{mul_widx[2:0], 5'd0} +: 32]} + {32'd0, carry_q};
  end

  always_comb begin
    capped = force_q ? limit : ((quo_q > limit) ? limit : quo_q);
    size = 8'd0;
    for (int i = 0; i < 256; i++) if (capped[i]) size = 8'((i + 8) / 8);
    if (size <= 8'd3) sh = capped << (8 * (3 - size));
    else sh = capped >> (8 * (size - 8'd3));
    c = sh[23:0];
    if (c[23]) begin
      c = c >> 8;
      size = size + 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      case (state_q)
        S_IDLE: if (req_valid_i) state_q <= req_i.force_limit ? S_ENC : S_MUL;
        S_MUL: if (mhalf_q && cnt_q[2:0] == 3'd7) state_q <= (div_q == '0) ? S_ENC : S_DIV;
        S_DIV: if (cnt_q == 9'd255) state_q <= S_ENC;
        S_ENC: state_q <= S_OUT;
        S_OUT: if (pop_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        acc_q <= req_i.target;
        mult_q <= req_i.mult;
        div_q <= req_i.divisor;
        force_q <= req_i.force_limit;
        mhalf_q <= 1'b0;
        quo_q <= '0;
        cnt_q <= '0;
        carry_q <= '0;
      end
      S_MUL: begin
        if (mhalf_q && cnt_q[2:0] == 3'd7) begin
          acc_q <= quo_q;
          quo_q <= '1;
          rem_q <= '0;
          cnt_q <= '0;
        end else begin
          if (!mul_widx[3]) quo_q[{mul_widx[2:0], 5'd0} +: 32] <= mul_p[31:0];
          carry_q <= (cnt_q[2:0] == 3'd7) ? 32'd0 : mul_p[63:32];
          cnt_q <= cnt_q + 9'd1;
          if (cnt_q[2:0] == 3'd7) mhalf_q <= 1'b1;
        end
      end
      S_DIV: begin
        acc_q <= acc_q << 1;
        cnt_q <= cnt_q + 9'd1;
        if (rem_sh >= {1'b0, div_q}) begin
          rem_q <= 64'(rem_sh - {1'b0, div_q});
          quo_q <= {quo_q[254:0], 1'b1};
        end else begin
          rem_q <= rem_sh[63:0];
          quo_q <= {quo_q[254:0], 1'b0};
        end
      end
      S_ENC: bits_q <= {size, c};
      default: ;
    endcase
  end
endmodule

[rtl/pow_difficulty_retarget.sv]
// Top level of the difficulty retarget block: config registers, front, back.
// Depends on pdr_pkg, pdr_front, pdr_back.
// Usage:
//  Requests enter through push/full; a request is taken when push is
//  high and full low. Results leave through empty/pop; the oldest result
//  is on next_bits_o and min_difficulty_used_o while empty is low.
//  The front registers the damped timespan and decoded target and holds one
//  request while the back is busy. The back loads a request, runs the
//  word-serial 256x64 multiply and the bit-serial divide, then encodes the
//  result; it takes a new request only after its result has been popped.
//  A limit-forced request skips multiply and divide.
//  Reset restores register defaults and empties both stages.
//  A stalled pop holds the result; the front still takes one more request.
//  Configuration must be written over APB only while idle; the block itself
//  does not enforce this.
module pow_difficulty_retarget
  import pdr_pkg::*;
#(
  parameter int unsigned LOOKBACK_WINDOW = 10
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [30:0] last_height_i,
  input  logic [31:0] last_time_i,
  input  logic [31:0] first_time_i,
  input  logic [31:0] last_bits_i,
  input  logic [35:0] window_time_sum_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] next_bits_o,
  output logic        min_difficulty_used_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [31:0] timespan_q, spacing_q, limit_q;
  logic        mode_q, req_valid, req_ready;
  pdr_req_t    req;

  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      RegTimespan: prdata = timespan_q;
      RegSpacing: prdata = spacing_q;
      RegMode: prdata = {31'd0, mode_q};
      RegLimit: prdata = limit_q;
      default: prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timespan_q <= 32'd14400;
      spacing_q <= 32'd60;
      mode_q <= 1'b1;
      limit_q <= 32'h1e0fffff;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      case (paddr[3:2])
        RegTimespan: timespan_q <= pwdata;
        RegSpacing: spacing_q <= pwdata;
        RegMode: mode_q <= pwdata[0];
        RegLimit: limit_q <= pwdata;
        default: ;
      endcase
    end
  end

  pdr_front #(.LOOKBACK_WINDOW(LOOKBACK_WINDOW)) u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .last_height_i, .last_time_i,
    .first_time_i, .last_bits_i, .window_time_sum_i, .timespan_i(timespan_q),
    .spacing_i(spacing_q), .mode_i(mode_q), .req_valid_o(req_valid),
    .req_ready_i(req_ready), .req_o(req)
  );

  pdr_back u_back (
    .clk_i, .rst_ni, .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req),
    .limit_bits_i(limit_q), .empty_o(empty), .pop_i(pop), .next_bits_o,
    .min_difficulty_used_o
  );
endmodule

[rtl/pdr_checker.sv]
// Port checker for the difficulty retarget block, bound to the top level.
// Depends on pow_difficulty_retarget_defines.svh.
`include "pow_difficulty_retarget_defines.svh"
module pdr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty,
  input logic        pop,
  input logic        pready,
  input logic [31:0] next_bits_o,
  input logic        min_difficulty_used_o
);
  `PDR_ASSERT_NEXT(a_hold, clk_i, rst_ni, !empty && !pop, $stable(next_bits_o))
  `PDR_ASSERT_NEXT(a_hold_min, clk_i, rst_ni, !empty && !pop, $stable(min_difficulty_used_o))
  `PDR_ASSERT_NEXT(a_pop, clk_i, rst_ni, !empty && pop, empty)
  `PDR_ASSERT_IMP(a_ready, clk_i, rst_ni, 1'b1, pready)
endmodule

bind pow_difficulty_retarget pdr_checker u_chk (.*);

[tb/sv/pow_difficulty_retarget_tb.sv]
`timescale 1ns / 100ps
// Testbench for the difficulty retarget block: directed and random requests over
// several register settings, checked against a built-in retarget predictor.
// Depends on pdr_pkg and pow_difficulty_retarget.
module pow_difficulty_retarget_tb;
  import pdr_pkg::*;

  localparam int unsigned Lookback = 10;
  localparam int unsigned DrainCycles = 400;
  localparam logic [35:0] WsumMax = 36'd42949672950;

  typedef struct packed {
    logic [30:0] last_height;
    logic [31:0] last_time;
    logic [31:0] first_time;
    logic [31:0] last_bits;
    logic [35:0] window_time_sum;
  } request_t;

  typedef struct packed {
    logic [31:0] next_bits;
    logic        min_used;
  } retarget_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [30:0] last_height_i = '0;
  logic [31:0] last_time_i = '0;
  logic [31:0] first_time_i = '0;
  logic [31:0] last_bits_i = '0;
  logic [35:0] window_time_sum_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] next_bits_o;
  logic        min_difficulty_used_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [31:0] timespan_q = 32'd14400;
  logic [31:0] spacing_q = 32'd60;
  logic        mode_q = 1'b1;
  logic [31:0] limit_bits_q = 32'h1e0fffff;

  retarget_t   expected_q[$];
  int unsigned mismatches = 0;
  int unsigned pop_pct = 100;

  pow_difficulty_retarget #(.LOOKBACK_WINDOW(Lookback)) i_dut (
    .clk_i, .rst_ni, .push, .full, .last_height_i, .last_time_i, .first_time_i,
    .last_bits_i, .window_time_sum_i, .empty, .pop, .next_bits_o,
    .min_difficulty_used_o, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata,
    .pready
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [255:0] unpack_target(input logic [31:0] w);
    logic [255:0] m;
    int unsigned  sz;
    m = {233'd0, w[22:0]};
    sz = {24'd0, w[31:24]};
    if (sz <= 3) return m >> (8 * (3 - sz));
    return m << (8 * (sz - 3));
  endfunction

  function automatic logic [31:0] pack_target(input logic [255:0] v);
    int unsigned  nb;
    int unsigned  sz;
    logic [255:0] sh;
    logic [31:0]  c;
    nb = 0;
    for (int i = 255; i >= 0; i--) begin
      if (v[i] && nb == 0) nb = i + 1;
    end
    sz = (nb + 7) / 8;
    if (sz <= 3) begin
      c = v[31:0] << (8 * (3 - sz));
    end else begin
      sh = v >> (8 * (sz - 3));
      c = sh[31:0];
    end
    c &= 32'h00ffffff;
    if (c[23]) begin
      c >>= 8;
      sz++;
    end
    return c | (sz << 24);
  endfunction

  function automatic retarget_t retarget(input request_t rq);
    longint       h, lt, ft, tspan, act, r, m, lo, hi, avg;
    logic [255:0] lim, t;
    retarget_t    res;
    h = longint'({33'd0, rq.last_height}) + 1;
    lt = longint'({32'd0, rq.last_time});
    ft = longint'({32'd0, rq.first_time});
    tspan = longint'({32'd0, timespan_q});
    act = lt - ft;
    r = tspan;
    m = act;
    lim = unpack_target(limit_bits_q);
    if (h < HeightMain) begin
      if (mode_q) begin
        m = tspan + (act - tspan) / 8;
        lo = tspan - tspan / 4;
        hi = tspan + tspan / 2;
      end else begin
        if (h > HeightBandA) lo = tspan / 4;
        else if (h > HeightBandB) lo = tspan / 8;
        else lo = tspan / 16;
        hi = tspan * 4;
      end
    end else begin
      r = tspan / 2;
      m = r + (act - r) / 4;
      lo = r / 2;
      hi = r * 2;
      avg = longint'({28'd0, rq.window_time_sum}) / Lookback;
      if (avg > lt + longint'({32'd0, spacing_q}) * 4) begin
        res.next_bits = pack_target(lim);
        res.min_used = 1'b1;
        return res;
      end
    end
    if (m < lo) m = lo;
    else if (m > hi) m = hi;
    t = unpack_target(rq.last_bits) * 256'(m);
    t = (r == 0) ? '1 : t / 256'(r);
    if (t > lim) t = lim;
    res.next_bits = pack_target(t);
    res.min_used = 1'b0;
    return res;
  endfunction

  task automatic send_request(input request_t rq);
    push <= 1'b1;
    last_height_i <= rq.last_height;
    last_time_i <= rq.last_time;
    first_time_i <= rq.first_time;
    last_bits_i <= rq.last_bits;
    window_time_sum_i <= rq.window_time_sum;
    do @(posedge clk_i); while (full);
    expected_q.push_back(retarget(rq));
  endtask

  task automatic hold_off(input int unsigned n);
    if (n == 0) return;
    push <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegTimespan: timespan_q = val;
      RegSpacing:  spacing_q = val;
      RegMode:     mode_q = val[0];
      default:     limit_bits_q = val;
    endcase
    @(posedge clk_i);
  endtask

  task automatic configure(input logic [31:0] ts, input logic [31:0] sp, input logic md,
                           input logic [31:0] lim);
    wait_drained();
    write_reg(RegTimespan, ts);
    write_reg(RegSpacing, sp);
    write_reg(RegMode, {31'd0, md});
    write_reg(RegLimit, lim);
  endtask

  function automatic logic [35:0] rand_wsum();
    logic [63:0] x;
    x = {$urandom(), $urandom()};
    return 36'(x % (64'(WsumMax) + 1));
  endfunction

  function automatic request_t random_request();
    request_t    rq;
    int unsigned k;
    longint      span;
    k = $urandom_range(0, 9);
    case (k)
      0: rq.last_height = 31'($urandom_range(0, 2147483646));
      1, 2: rq.last_height = 31'($urandom_range(4990, 10020));
      3, 4, 5: rq.last_height = 31'($urandom_range(999990, 1000010) + $urandom_range(0, 1) *
                                    $urandom_range(0, 100000000));
      default: rq.last_height = 31'($urandom_range(0, 999998));
    endcase
    rq.last_time = $urandom();
    span = longint'({32'd0, timespan_q});
    if ($urandom_range(0, 4) == 0) begin
      rq.first_time = $urandom();
    end else begin
      span = span * $urandom_range(0, 60) / 10 - longint'($urandom_range(0, 1000));
      rq.first_time = rq.last_time - 32'(span);
    end
    if ($urandom_range(0, 4) == 0) rq.last_bits = $urandom();
    else rq.last_bits = {8'($urandom_range(3, 33)), 24'($urandom())};
    if ($urandom_range(0, 3) == 0) begin
      rq.window_time_sum = rand_wsum();
    end else begin
      rq.window_time_sum = 36'(longint'({32'd0, rq.last_time}) * 10 +
                          longint'({32'd0, spacing_q}) * $urandom_range(30, 50) +
                          $urandom_range(0, 19) - 10);
      if (rq.window_time_sum > WsumMax) rq.window_time_sum = WsumMax;
    end
    return rq;
  endfunction

  task automatic send_random(input int unsigned n);
    int unsigned left;
    int unsigned burst;
    left = n;
    while (left != 0) begin
      burst = $urandom_range(1, 8);
      if (burst > left) burst = left;
      repeat (burst) send_request(random_request());
      left -= burst;
      hold_off($urandom_range(0, 1) ? 0 : $urandom_range(1, 40));
    end
  endtask

  task automatic test_directed();
    request_t rq;
    logic [30:0] heights[8] = '{31'd0, 31'd4999, 31'd5000, 31'd9999, 31'd10000,
                                31'd999998, 31'd999999, 31'd2147483646};
    logic [31:0] words[8] = '{32'h00000000, 32'hffffffff, 32'h01123456, 32'h037fffff,
                              32'h1d00ffff, 32'h20ffffff, 32'h22123456, 32'h23800001};
    for (int i = 0; i < 8; i++) begin
      rq.last_height = heights[i];
      rq.last_time = (i % 2) ? 32'hffffffff : 32'd0;
      rq.first_time = (i % 2) ? 32'd0 : 32'hffffffff;
      rq.last_bits = words[i];
      rq.window_time_sum = (i % 2) ? 36'd0 : WsumMax;
      send_request(rq);
    end
    for (int i = 0; i < 8; i++) begin
      rq.last_height = heights[7 - i];
      rq.last_time = 32'd1000000 + 32'(i);
      rq.first_time = rq.last_time - timespan_q * 32'(i) / 4;
      rq.last_bits = words[(i + 3) % 8];
      rq.window_time_sum = 36'(64'(rq.last_time) * 10 + 64'(spacing_q) * 40 + i - 4);
      send_request(rq);
    end
    hold_off(1);
  endtask

  task automatic test_minimum_settings();
    configure(32'd2, 32'd1, 1'b0, 32'h00000000);
    send_random(60);
    configure(32'd3, 32'd1, 1'b1, 32'h04800000);
    test_directed();
    send_random(60);
  endtask

  task automatic test_maximum_settings();
    configure(32'hffffffff, 32'hffffffff, 1'b1, 32'hffffffff);
    test_directed();
    send_random(100);
    configure(32'hffffffff, 32'h00000001, 1'b0, 32'h207fffff);
    send_random(100);
  endtask

  task automatic test_random_settings();
    for (int i = 0; i < 12; i++) begin
      configure($urandom_range(2, 100000), $urandom_range(1, 1000), 1'($urandom()),
                {8'($urandom_range(0, 40)), 24'($urandom())});
      send_random(80);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: bits %h min %b", next_bits_o,
                                       min_difficulty_used_o);
      end else begin
        if (next_bits_o !== expected_q[0].next_bits ||
            min_difficulty_used_o !== expected_q[0].min_used) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected bits %h min %b, got bits %h min %b",
                     expected_q[0].next_bits, expected_q[0].min_used, next_bits_o,
                     min_difficulty_used_o);
        end
        void'(expected_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ($urandom_range(0, 499) == 0) begin
      case ($urandom_range(0, 2))
        0: pop_pct <= 100;
        1: pop_pct <= 50;
        default: pop_pct <= 5;
      endcase
    end
    pop <= ($urandom_range(0, 99) < pop_pct);
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    send_random(200);
    test_minimum_settings();
    test_maximum_settings();
    test_random_settings();
    configure(32'd14400, 32'd60, 1'b1, 32'h1e0fffff);
    send_random(200);
    wait_drained();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("end of test: mismatches");
    $finish;
  end
endmodule

[filelist.f]
+incdir+rtl
rtl/pdr_pkg.sv
rtl/pdr_front.sv
rtl/pdr_back.sv
rtl/pow_difficulty_retarget.sv
rtl/pdr_checker.sv
tb/sv/pow_difficulty_retarget_tb.sv
